// File: src/tsss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared types and constants of the throttle soft start shaper.
// ----------------------------------------------------------------------------
package tsss_pkg;

  localparam int unsigned MAG_W = 10;  // magnitude of ramp slope, thousandths
  localparam int unsigned MS_W  = 16;  // millisecond fields
  localparam int unsigned QUO_W = 10;  // quotient of the ramp division
  localparam int unsigned PRD_W = MAG_W + MS_W;

  localparam logic [3:0] MUL_LAST = 4'd15;
  localparam logic [3:0] DIV_LAST = 4'd9;

  localparam logic [1:0] CFG_SOFT_START_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_WARMUP_MS           = 2'd1;
  localparam logic [1:0] CFG_INITIAL_LIMIT_MILLI = 2'd2;
  localparam logic [1:0] CFG_MAX_STEP_MILLI      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] q;
    logic             inexact;
  } ser_res_t;

endpackage
`default_nettype wire

// File: src/tsss_ramp_serial.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_ramp_serial
// Bit-serial ramp term: shift-and-add product of slope and elapsed time,
// then restoring division by the warmup length, one bit per cycle.
// ----------------------------------------------------------------------------
module tsss_ramp_serial
  import tsss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] md,
  input  wire logic [MS_W-1:0]  e,
  input  wire logic [MS_W-1:0]  w,
  output ser_res_t              res
);

  phase_t phase, phase_next;
  logic [3:0] cnt, cnt_next;

  logic [MAG_W-1:0] md_r;
  logic [MS_W-1:0]  w_r;
  logic [PRD_W-1:0] p, p_next;
  logic [MS_W-1:0]  rem, rem_next;
  logic [QUO_W-1:0] lo, lo_next;

  logic [MAG_W:0]   psum;
  logic [MS_W:0]    trial;
  logic             ge;

  // product step: add slope into the upper part, shift right
  always_comb begin
    psum   = {1'b0, p[PRD_W-1:MS_W]} + (p[0] ? {1'b0, md_r} : '0);
    p_next = {psum, p[MS_W-1:1]};
  end

  // division step
  always_comb begin
    trial    = {rem, lo[QUO_W-1]};
    ge       = trial >= {1'b0, w_r};
    rem_next = ge ? MS_W'(trial - {1'b0, w_r}) : trial[MS_W-1:0];
    lo_next  = {lo[QUO_W-2:0], ge};
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (start) phase_next = PH_MUL;
      PH_MUL:  if (cnt == MUL_LAST) phase_next = PH_DIV;
      PH_DIV:  if (cnt == DIV_LAST) phase_next = PH_DONE;
      PH_DONE: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    if (phase == PH_IDLE || (phase == PH_MUL && cnt == MUL_LAST) ||
        (phase == PH_DIV && cnt == DIV_LAST)) begin
      cnt_next = '0;
    end else begin
      cnt_next = cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          p    <= {{MAG_W{1'b0}}, e};
          md_r <= md;
          w_r  <= w;
        end
      end
      PH_MUL: begin
        p <= p_next;
        if (cnt == MUL_LAST) begin
          rem <= p_next[PRD_W-1:QUO_W];
          lo  <= p_next[QUO_W-1:0];
        end
      end
      PH_DIV: begin
        rem <= rem_next;
        lo  <= lo_next;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.done    = phase == PH_DONE;
    res.q       = lo;
    res.inexact = rem != '0;
  end

endmodule
`default_nettype wire

// File: src/throttle_soft_start_shaper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// throttle_soft_start_shaper
// Throttle percent and steering angle with slew limit and warmup ceiling.
// ----------------------------------------------------------------------------
// one item at a time: no new item is taken until the serial product and
//   serial division of the warmup ceiling are done and the result is loaded
// in_ready returns while a finished item still waits at the output register
// synchronous reset: registers to their defaults, held throttle to zero
module throttle_soft_start_shaper
  import tsss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] throttle_command_milli,
  input  wire logic signed [15:0] steer_command_milli,
  input  wire logic [15:0]        elapsed_ms,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [5:0]       speed_command,
  output logic signed [6:0]       steering_angle,
  output logic [9:0]              held_throttle_milli
);

  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] prod;
    begin
      prod  = {8'b0, x} * 18'd205;
      div10 = prod[17:11];
    end
  endfunction

  // configuration
  logic        soft_en;
  logic [15:0] warmup;
  logic [9:0]  ini;
  logic [9:0]  max_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_en  <= 1'b1;
      warmup   <= 16'd3000;
      ini      <= 10'd100;
      max_step <= 10'd20;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SOFT_START_ENABLE:   soft_en  <= cfg_data[0];
        CFG_WARMUP_MS:           warmup   <= cfg_data;
        CFG_INITIAL_LIMIT_MILLI: ini      <= cfg_data[9:0];
        CFG_MAX_STEP_MILLI:      max_step <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic accept, start, load;
  logic [9:0] held;

  // front end, evaluated on the accepted item
  logic [9:0]         held_eff;
  logic [6:0]         pct_raw;
  logic [4:0]         pct;
  logic [7:0]         target;
  logic [16:0]        str_mag;
  logic [29:0]        ang_prod;
  logic [5:0]         ang_mag;
  logic [6:0]         angle;
  logic signed [11:0] diff;
  logic signed [11:0] step_s;
  logic [9:0]         h;
  logic signed [11:0] d;
  logic [11:0]        d_abs;

  always_comb begin
    held_eff = restart ? '0 : held;
    pct_raw  = div10({1'b0, throttle_command_milli[8:0]});
    if (throttle_command_milli[15]) begin
      pct = '0;
    end else if (throttle_command_milli >= 16'sd260) begin
      pct = 5'd25;
    end else begin
      pct = pct_raw[4:0];
    end
    target = {pct, 3'b000} + {2'b00, pct, 1'b0};

    str_mag  = steer_command_milli[15] ? 17'd0 - {1'b1, steer_command_milli}
                                       : {1'b0, steer_command_milli};
    ang_prod = {20'b0, str_mag[9:0]} * 30'd754975;
    ang_mag  = (str_mag >= 17'd1023) ? 6'd45 : ang_prod[29:24];
    angle    = steer_command_milli[15] ? 7'd0 - {1'b0, ang_mag} : {1'b0, ang_mag};

    diff   = $signed({4'b0, target}) - $signed({2'b0, held_eff});
    step_s = $signed({2'b0, max_step});
    if (diff > step_s) begin
      h = held_eff + max_step;
    end else if (diff < -step_s) begin
      h = held_eff - max_step;
    end else begin
      h = {2'b0, target};
    end

    d     = $signed({4'b0, target}) - $signed({2'b0, ini});
    d_abs = d[11] ? 12'(-d) : d;
  end

  ser_res_t ramp_res;

  tsss_ramp_serial u_ramp (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .md    (d_abs[9:0]),
    .e     (elapsed_ms),
    .w     (warmup),
    .res   (ramp_res)
  );

  // item held while the ramp term is worked out
  logic [9:0] h_r;
  logic [7:0] target_r;
  logic [6:0] angle_r;
  logic       ramp_r;
  logic       dneg_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      h_r      <= h;
      target_r <= target;
      angle_r  <= angle;
      ramp_r   <= elapsed_ms < warmup;
      dneg_r   <= d[11];
    end
  end

  // back end: ceiling, clamp, percent
  logic [10:0] q_up;
  logic [10:0] ceil_v;
  logic [9:0]  hf;
  logic [9:0]  fin;
  logic [6:0]  fin_pct;

  always_comb begin
    q_up = {1'b0, ramp_res.q} + {10'b0, ramp_res.inexact};
    if (!ramp_r) begin
      ceil_v = {3'b0, target_r};
    end else if (dneg_r) begin
      ceil_v = ({1'b0, ini} >= q_up) ? {1'b0, ini} - q_up : '0;
    end else begin
      ceil_v = {1'b0, ini} + {1'b0, ramp_res.q};
    end
    hf      = ({1'b0, h_r} < ceil_v) ? h_r : ceil_v[9:0];
    fin     = soft_en ? hf : {2'b0, target_r};
    fin_pct = div10(fin);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_RUN;
      ST_RUN:  if (ramp_res.done) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == ST_IDLE;
    accept   = in_ready && in_valid;
    start    = accept;
    load     = (state == ST_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      held      <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        held <= held_eff;
      end else if (load && soft_en) begin
        held <= hf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      speed_command       <= 6'(7'd0 - fin_pct);
      steering_angle      <= angle_r;
      held_throttle_milli <= soft_en ? hf : held;
    end
  end

endmodule
`default_nettype wire

// File: src/tsss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_port_checks
// Port-level checks of the throttle soft start shaper.
// ----------------------------------------------------------------------------
module tsss_port_checks (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [5:0]  speed_command,
  input wire logic signed [6:0]  steering_angle,
  input wire logic [9:0]         held_throttle_milli
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(speed_command) &&
    $stable(steering_angle) && $stable(held_throttle_milli))
    else $error("stalled output item changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is at work");

  a_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> steering_angle <= 7'sd45 && steering_angle >= -7'sd45)
    else $error("steering angle out of range");

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_throttle_milli <= 10'd1000)
    else $error("held throttle out of range");

endmodule

bind throttle_soft_start_shaper tsss_port_checks u_tsss_port_checks (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .speed_command       (speed_command),
  .steering_angle      (steering_angle),
  .held_throttle_milli (held_throttle_milli)
);
`default_nettype wire

// File: bench/tsss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_checker
// Watches the input, output and register ports of the throttle shaper. It
// keeps its own copy of the registers and the held throttle, works out the
// expected speed, steering and held values for every accepted item, and
// compares each accepted result field by field with the oldest one pending.
// ----------------------------------------------------------------------------
module tsss_checker
  import tsss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] throttle_command_milli,
  input  logic signed [15:0] steer_command_milli,
  input  logic [15:0]        elapsed_ms,
  input  logic               restart,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [5:0]  speed_command,
  input  logic signed [6:0]  steering_angle,
  input  logic [9:0]         held_throttle_milli,
  output int                 pending,
  output int                 errors
);

  localparam int PCT_MAX    = 25;
  localparam int ANGLE_MAX  = 45;
  localparam int FULL_SCALE = 1000;
  localparam int RAMP_SLOPE = 300;

  typedef struct packed {
    logic signed [5:0] speed;
    logic signed [6:0] angle;
    logic [9:0]        held;
  } shaped_cmd_t;

  shaped_cmd_t expected_cmds[$];
  shaped_cmd_t oldest;

  logic        ss_enable;
  logic [15:0] warm_ms;
  int          init_milli;
  int          step_milli;
  int          held_milli;
  int          mismatches = 0;

  assign errors = mismatches;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic shaped_cmd_t shape_step(input logic signed [15:0] thr_cmd,
                                             input logic signed [15:0] str_cmd,
                                             input logic [15:0] el,
                                             input logic rs);
    int          pct;
    int          angle;
    int          target;
    int          diff;
    int          next_held;
    int          final_milli;
    longint      w;
    longint      e;
    longint      ini;
    longint      lin;
    longint      lim;
    longint      num;
    longint      ceil_milli;
    shaped_cmd_t r;
    if (rs) held_milli = 0;
    pct = (thr_cmd < 0) ? 0 : int'(thr_cmd) / 10;
    if (pct > PCT_MAX) pct = PCT_MAX;
    angle = (int'(str_cmd) * ANGLE_MAX) / FULL_SCALE;
    if (angle > ANGLE_MAX) angle = ANGLE_MAX;
    if (angle < -ANGLE_MAX) angle = -ANGLE_MAX;
    target = pct * 10;
    if (ss_enable) begin
      diff = target - held_milli;
      if (diff > step_milli) begin
        next_held = held_milli + step_milli;
      end else if (diff < -step_milli) begin
        next_held = held_milli - step_milli;
      end else begin
        next_held = target;
      end
      if (el < warm_ms) begin
        // ceiling ramps from the initial limit, over the warmup length
        w   = longint'(warm_ms);
        e   = longint'(el);
        ini = longint'(init_milli);
        lin = ini * w + (longint'(target) - ini) * e;
        lim = ini * w + RAMP_SLOPE * e;
        num = (lin < lim) ? lin : lim;
        if (num < 0) num = 0;
        ceil_milli = num / w;
      end else begin
        ceil_milli = longint'(target);
      end
      if (longint'(next_held) > ceil_milli) next_held = int'(ceil_milli);
      if (next_held < 0) next_held = 0;
      if (next_held > FULL_SCALE) next_held = FULL_SCALE;
      held_milli  = next_held;
      final_milli = next_held;
    end else begin
      final_milli = target;
    end
    r.speed = 6'(-(final_milli / 10));
    r.angle = 7'(angle);
    r.held  = 10'(held_milli);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ss_enable  = 1'b1;
      warm_ms    = 16'd3000;
      init_milli = 100;
      step_milli = 20;
      held_milli = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SOFT_START_ENABLE:   ss_enable  = cfg_data[0];
          CFG_WARMUP_MS:           warm_ms    = cfg_data;
          CFG_INITIAL_LIMIT_MILLI: init_milli = int'(cfg_data[9:0]);
          CFG_MAX_STEP_MILLI:      step_milli = int'(cfg_data[9:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          report("result with nothing pending");
        end else begin
          oldest = expected_cmds.pop_front();
          if (speed_command !== oldest.speed)
            report($sformatf("speed_command got %0d want %0d", speed_command, oldest.speed));
          if (steering_angle !== oldest.angle)
            report($sformatf("steering_angle got %0d want %0d", steering_angle,
                             oldest.angle));
          if (held_throttle_milli !== oldest.held)
            report($sformatf("held_throttle_milli got %0d want %0d", held_throttle_milli,
                             oldest.held));
        end
      end
      if (in_valid && in_ready)
        expected_cmds.push_back(shape_step(throttle_command_milli, steer_command_milli,
                                           elapsed_ms, restart));
    end
    pending <= expected_cmds.size();
  end

endmodule

// File: bench/tb_throttle_soft_start_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_throttle_soft_start_shaper
// Drives the throttle shaper with directed corner items and then with
// soft-start runs of rising elapsed time under several register settings,
// mixed with random noise items, random idling on both sides, a long output
// stall and drained pauses. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_throttle_soft_start_shaper;
  import tsss_pkg::*;

  localparam int STALL_CYCLES = 250;
  localparam int TAIL_CYCLES  = 40;
  localparam int STALL_ITEMS  = 20;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] throttle_command_milli;
  logic signed [15:0] steer_command_milli;
  logic [15:0]        elapsed_ms;
  logic               restart;
  logic               out_valid;
  logic               out_ready;
  logic signed [5:0]  speed_command;
  logic signed [6:0]  steering_angle;
  logic [9:0]         held_throttle_milli;
  int                 pending;
  int                 errors;
  logic               idle_en;
  logic               stall_req;

  throttle_soft_start_shaper u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .throttle_command_milli(throttle_command_milli),
    .steer_command_milli(steer_command_milli),
    .elapsed_ms(elapsed_ms),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .speed_command(speed_command),
    .steering_angle(steering_angle),
    .held_throttle_milli(held_throttle_milli)
  );

  tsss_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .throttle_command_milli(throttle_command_milli),
    .steer_command_milli(steer_command_milli),
    .elapsed_ms(elapsed_ms),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .speed_command(speed_command),
    .steering_angle(steering_angle),
    .held_throttle_milli(held_throttle_milli),
    .pending(pending),
    .errors(errors)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end
      out_ready <= !idle_en || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_item(input int thr, input int str, input int el, input int rs);
    while (idle_en && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    throttle_command_milli <= 16'(thr);
    steer_command_milli    <= 16'(str);
    elapsed_ms             <= 16'(el);
    restart                <= rs[0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_noise();
    send_item(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
              int'($urandom_range(65535)), int'($urandom_range(1)));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int en, input int warm, input int ini, input int step);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SOFT_START_ENABLE;
    cfg_data  <= 16'(en);
    @(posedge clk);
    cfg_index <= CFG_WARMUP_MS;
    cfg_data  <= 16'(warm);
    @(posedge clk);
    cfg_index <= CFG_INITIAL_LIMIT_MILLI;
    cfg_data  <= 16'(ini);
    @(posedge clk);
    cfg_index <= CFG_MAX_STEP_MILLI;
    cfg_data  <= 16'(step);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one soft-start run: restart, then rising elapsed time
  task automatic run_ramp(input int len, input int max_gap);
    int el;
    int thr;
    el = 0;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0:       thr = -int'($urandom_range(1, 600));
        1:       thr = int'($urandom_range(251, 32767));
        default: thr = int'($urandom_range(0, 300));
      endcase
      send_item(thr, int'($urandom_range(2400)) - 1200, el, (k == 0) ? 1 : 0);
      el += int'($urandom_range(max_gap));
      if (el > 65535) el = 65535;
    end
  endtask

  task automatic run_phase(input int en, input int warm, input int ini, input int step,
                           input int n_items);
    int sent;
    int len;
    wait_drain();
    apply_settings(en, warm, ini, step);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        send_noise();
        sent++;
      end else begin
        len = int'($urandom_range(10, 50));
        run_ramp(len, (warm == 0) ? 200 : warm / 20 + 1);
        sent += len;
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = CFG_SOFT_START_ENABLE;
    cfg_data               = 16'd0;
    in_valid               = 1'b0;
    throttle_command_milli = 16'sd0;
    steer_command_milli    = 16'sd0;
    elapsed_ms             = 16'd0;
    restart                = 1'b0;
    idle_en                = 1'b1;
    stall_req              = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners under the reset settings
    send_item(0, 0, 0, 1);
    send_item(32767, 32767, 0, 0);
    send_item(32767, -32768, 1500, 0);
    send_item(250, 1000, 2999, 0);
    send_item(251, -1000, 3000, 0);
    send_item(249, 23, 65535, 0);
    send_item(10, -23, 65535, 0);
    send_item(9, 22, 65535, 0);
    send_item(-1, -22, 65535, 0);
    send_item(-32768, 0, 65535, 0);
    send_item(250, 32767, 0, 1);
    for (int k = 1; k <= 6; k++) send_item(300, 500, k * 400, 0);

    // soft start off, then zero warmup with out-of-range registers
    wait_drain();
    apply_settings(0, 0, 1023, 1023);
    send_item(250, 1000, 0, 0);
    send_item(-5, -1000, 100, 1);
    send_item(137, 0, 65535, 0);
    wait_drain();
    apply_settings(1, 0, 1023, 1023);
    send_item(250, 444, 0, 0);
    send_item(120, -445, 0, 0);
    send_item(251, 1, 65535, 1);

    run_phase(1, 3000, 100, 20, 250);
    run_phase(1, 0, 0, 0, 250);
    idle_en = 1'b0;
    run_phase(1, 65535, 1023, 1023, 250);
    idle_en = 1'b1;
    run_phase(0, int'($urandom_range(1, 65535)), int'($urandom_range(1023)),
              int'($urandom_range(1023)), 250);
    run_phase(1, 1, 1000, 1000, 250);
    // sender keeps offering items while the result side holds off
    stall_req = 1'b1;
    for (int k = 0; k < STALL_ITEMS; k++) send_noise();
    run_phase(1, 500, 0, 1023, 250);
    run_phase(1, int'($urandom_range(1, 5000)), int'($urandom_range(1023)),
              int'($urandom_range(1, 100)), 250);
    run_phase(1, int'($urandom_range(1, 65535)), int'($urandom_range(1023)),
              int'($urandom_range(1, 100)), 250);

    wait_drain();
    if (errors == 0) begin
      $display("[throttle_soft_start_shaper] OK");
    end else begin
      $display("[throttle_soft_start_shaper] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[throttle_soft_start_shaper] ERROR");
    $finish;
  end

endmodule

// File: files.f
src/tsss_pkg.sv
src/tsss_ramp_serial.sv
src/throttle_soft_start_shaper.sv
src/tsss_checker.sv
bench/tsss_checker.sv
bench/tb_throttle_soft_start_shaper.sv
